// ===== rtl/core/timed_event_queue_assert.svh =====
// Assertion macros for the timed event queue.
// Included by the top level; no other dependencies.
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define TEQ_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("timed_event_queue: invariant violated");
`define TEQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timed_event_queue: implication violated");
`else
`define TEQ_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define TEQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/teq_pkg.sv =====
// Types and constants shared by the timed event queue.
// No dependencies.
package teq_pkg;

  localparam int TYPE_BITS = 3;
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS-1:0] NO_EVENTS = 32'hffff_ffff;
  localparam logic [TIME_BITS-1:0] FRAME_RESET = 32'd69888;

  localparam logic REG_FRAME_LENGTH = 1'b0;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_FIRED = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam logic [TYPE_BITS-1:0] TYPE_NULL = '0;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_RUN    = 2'd1,
    CMD_REBASE = 2'd2,
    CMD_CANCEL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_REBASE,
    OP_CANCEL
  } op_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [TIME_BITS-1:0] due_at;
    logic [TYPE_BITS-1:0] event_type;
    logic [TIME_BITS-1:0] now;
  } req_t;

  typedef struct packed {
    logic                 kind;
    logic                 status;
    logic [TYPE_BITS-1:0] fired_type;
    logic [TIME_BITS-1:0] fired_time;
    logic [TIME_BITS-1:0] next_due;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] due;
    logic [TYPE_BITS-1:0] etype;
  } entry_t;

  typedef struct packed {
    op_t                  op;
    logic [TIME_BITS-1:0] due;
    logic [TYPE_BITS-1:0] etype;
    logic [TIME_BITS-1:0] frame;
  } cell_ctl_t;

endpackage

// ===== rtl/core/teq_cell.sv =====
// One slot of the event queue chain: holds one entry and trades it with its neighbors.
// Depends on teq_pkg.
module teq_cell (
  input  logic               clk,
  input  logic               rst,
  input  teq_pkg::cell_ctl_t ctl,
  input  teq_pkg::entry_t    left,
  input  teq_pkg::entry_t    right,
  input  logic               found_in,
  output logic               found_out,
  output teq_pkg::entry_t    entry
);

  teq_pkg::entry_t entry_next;
  logic            hit;

  // First free slot, or first slot whose time is not below the new one.
  assign hit       = !entry.valid || !(ctl.due > entry.due);
  assign found_out = found_in || hit;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      teq_pkg::OP_INSERT: begin
        if (found_in) begin
          entry_next = left;
        end else if (hit) begin
          entry_next.valid = 1'b1;
          entry_next.due   = ctl.due;
          entry_next.etype = ctl.etype;
        end
      end
      teq_pkg::OP_POP: begin
        entry_next = right;
      end
      teq_pkg::OP_REBASE: begin
        if (entry.valid) begin
          entry_next.due = entry.due - ctl.frame;
        end
      end
      teq_pkg::OP_CANCEL: begin
        if (entry.valid && entry.etype == ctl.etype) begin
          entry_next.etype = teq_pkg::TYPE_NULL;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry.due   <= entry_next.due;
    entry.etype <= entry_next.etype;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

// ===== rtl/core/timed_event_queue.sv =====
// Timed event queue top level: command sequencer, config register and cell chain.
// Depends on teq_pkg, teq_cell and timed_event_queue_assert.svh.
//
// Usage:
//   Commands enter on request, taken at a clock edge with start high and busy low.
//   add inserts an event ahead of stored events of equal or later time; run pops
//   head entries while due at or before request.now; rebase subtracts frame_length
//   from every stored time; cancel nulls every entry of request.event_type.
//   Results leave on result, each valid for exactly one cycle under result_valid.
//   The receiver cannot stall; every result must be taken in the cycle it shows.
//   Each command ends with one acknowledgement (kind 0, last 1); run also emits
//   one fired item (kind 1) per non-null event popped, ahead of its ack.
// Sequencing:
//   add, rebase, cancel: the accepting edge moves the sequencer to its execute
//   state, which registers the ack and returns to idle; a new command can be
//   accepted at the edge that takes the ack, so commands do not overlap.
//   run: stays in the execute state while the head is due, popping one head
//   entry per cycle (null ones included), then registers its ack.
// Reset:
//   rst (synchronous) empties the queue, frees the sequencer and sets
//   frame_length to 69888. frame_length lives at byte address 0 of the APB port.
`include "timed_event_queue_assert.svh"

module timed_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  teq_pkg::req_t       request,
  output logic                busy,
  output logic                result_valid,
  output teq_pkg::res_t       result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                         state;
  teq_pkg::req_t                  req;
  logic [teq_pkg::TIME_BITS-1:0]  frame_length;

  teq_pkg::entry_t                cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]           found;
  logic [QUEUE_DEPTH-1:0]         occ;
  teq_pkg::cell_ctl_t             ctl;

  logic [teq_pkg::TIME_BITS-1:0]  earliest;
  logic [teq_pkg::TIME_BITS-1:0]  second_due;
  logic [teq_pkg::TIME_BITS-1:0]  ack_next_due;
  logic                           full;
  logic                           due_now;
  logic                           ack_status;
  logic                           ack_shown;

  // Config port: one register, word index taken from paddr[2].
  assign pready = 1'b1;
  assign prdata = (paddr[2] == teq_pkg::REG_FRAME_LENGTH) ? frame_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= teq_pkg::FRAME_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == teq_pkg::REG_FRAME_LENGTH) begin
      frame_length <= pwdata;
    end
  end

  // Cell chain: entry 0 is the head. Inserts ripple the search flag toward the
  // tail and shift later entries back; pops shift everything toward the head.
  assign found[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    teq_pkg::entry_t left_e;
    teq_pkg::entry_t right_e;
    if (g == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = cells[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[g+1];
    end
    teq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .left     (left_e),
      .right    (right_e),
      .found_in (found[g]),
      .found_out(found[g+1]),
      .entry    (cells[g])
    );
    assign occ[g] = cells[g].valid;
  end

  // Head time stands in for the earliest due time, since add always lands in front
  // of any entry not earlier than itself; a rebase that wraps can break this.
  assign earliest   = cells[0].valid ? cells[0].due : teq_pkg::NO_EVENTS;
  assign second_due = cells[1].valid ? cells[1].due : teq_pkg::NO_EVENTS;
  assign full       = cells[QUEUE_DEPTH-1].valid;
  assign due_now    = cells[0].valid && (cells[0].due <= req.now);
  assign busy       = (state != S_IDLE);
  assign ack_shown  = result_valid && (result.kind == teq_pkg::KIND_ACK);

  // Drive the chain from the latched command.
  always_comb begin
    ctl.op    = teq_pkg::OP_HOLD;
    ctl.due   = req.due_at;
    ctl.etype = req.event_type;
    ctl.frame = frame_length;
    if (state == S_EXEC) begin
      case (req.cmd)
        teq_pkg::CMD_ADD:    ctl.op = full ? teq_pkg::OP_HOLD : teq_pkg::OP_INSERT;
        teq_pkg::CMD_RUN:    ctl.op = due_now ? teq_pkg::OP_POP : teq_pkg::OP_HOLD;
        teq_pkg::CMD_REBASE: ctl.op = teq_pkg::OP_REBASE;
        teq_pkg::CMD_CANCEL: ctl.op = teq_pkg::OP_CANCEL;
        default:             ctl.op = teq_pkg::OP_HOLD;
      endcase
    end
  end

  // Head due time as it will stand once the chain takes this command.
  always_comb begin
    ack_next_due = earliest;
    ack_status   = teq_pkg::STATUS_OK;
    case (req.cmd)
      teq_pkg::CMD_ADD: begin
        if (full) begin
          ack_status = teq_pkg::STATUS_FULL;
        end else if (req.due_at < earliest) begin
          ack_next_due = req.due_at;
        end
      end
      teq_pkg::CMD_REBASE: begin
        ack_next_due = cells[0].valid ? cells[0].due - frame_length
                                      : teq_pkg::NO_EVENTS;
      end
      default: begin
        ack_next_due = earliest;
      end
    endcase
  end

  // Sequencer: latch the command, then execute; run stays here, popping one
  // due entry per cycle, and every command leaves with its ack.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= request;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req.cmd == teq_pkg::CMD_RUN && due_now) begin
            // Pop the head; null events leave silently.
            if (cells[0].etype != teq_pkg::TYPE_NULL) begin
              result_valid      <= 1'b1;
              result.kind       <= teq_pkg::KIND_FIRED;
              result.status     <= teq_pkg::STATUS_OK;
              result.fired_type <= cells[0].etype;
              result.fired_time <= cells[0].due;
              result.next_due   <= second_due;
              result.last       <= 1'b0;
            end
          end else begin
            result_valid      <= 1'b1;
            result.kind       <= teq_pkg::KIND_ACK;
            result.status     <= ack_status;
            result.fired_type <= teq_pkg::TYPE_NULL;
            result.fired_time <= '0;
            result.next_due   <= ack_next_due;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the chain.
  `TEQ_ASSERT_ALWAYS(a_occ_packed, clk, rst, $onehot({1'b0, occ} + 1'b1))
  `TEQ_ASSERT_IMPLY(a_insert_slot, clk, rst, ctl.op == teq_pkg::OP_INSERT, found[QUEUE_DEPTH])
  `TEQ_ASSERT_IMPLY(a_last_idle, clk, rst, result_valid && result.last, !busy)
  `TEQ_ASSERT_IMPLY(a_ack_head, clk, rst, ack_shown, result.next_due == earliest)

endmodule

// ===== bench/timed_event_queue_tb.sv =====
// Self-checking bench for the timed event queue: directed corner cases, then random traffic.
// Depends on teq_pkg and the timed_event_queue RTL; needs no files or arguments.
module timed_event_queue_tb;

  localparam int DEPTH = 16;
  // Longest legal quiet stretch is a long sender gap plus a 16-pop run; allow far more.
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] FRAME_ADDR = {teq_pkg::REG_FRAME_LENGTH, 2'b00};

  logic          clk;
  logic          rst;
  logic          start;
  teq_pkg::req_t request;
  logic          busy;
  logic          result_valid;
  teq_pkg::res_t result;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  timed_event_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the queue: entry 0 is the head.
  logic [teq_pkg::TIME_BITS-1:0] sched_due [DEPTH];
  logic [teq_pkg::TYPE_BITS-1:0] sched_type [DEPTH];
  int                            sched_count;
  logic [teq_pkg::TIME_BITS-1:0] sched_head;
  logic [teq_pkg::TIME_BITS-1:0] frame_len;

  // Acks and fired events still owed by the block, oldest first.
  teq_pkg::res_t awaited_results[$];

  int  err_count;
  int  n_items;
  int  n_fired;
  int  n_dropped;
  int  n_rebases;
  int  stall_cycles;
  bit  quiet_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [teq_pkg::TYPE_BITS-1:0] rand_type();
    logic [31:0] v;
    v = $urandom_range(0, 7);
    return v[teq_pkg::TYPE_BITS-1:0];
  endfunction

  function automatic teq_pkg::cmd_t rand_cmd();
    logic [31:0] v;
    v = $urandom_range(0, 3);
    return teq_pkg::cmd_t'(v[1:0]);
  endfunction

  function automatic void owe_result(logic kind, logic status,
                                     logic [teq_pkg::TYPE_BITS-1:0] typ,
                                     logic [teq_pkg::TIME_BITS-1:0] tim, logic last);
    teq_pkg::res_t r;
    r.kind       = kind;
    r.status     = status;
    r.fired_type = typ;
    r.fired_time = tim;
    r.next_due   = sched_head;
    r.last       = last;
    awaited_results.push_back(r);
  endfunction

  // Advance the shadow queue by one command and record every result it owes.
  function automatic void queue_apply(teq_pkg::req_t r);
    int                            pos;
    logic [teq_pkg::TIME_BITS-1:0] popped_time;
    logic [teq_pkg::TYPE_BITS-1:0] popped_type;
    case (r.cmd)
      teq_pkg::CMD_ADD: begin
        if (sched_count >= DEPTH) begin
          n_dropped++;
          owe_result(teq_pkg::KIND_ACK, teq_pkg::STATUS_FULL, teq_pkg::TYPE_NULL,
                     '0, 1'b1);
        end else begin
          // Insert ahead of the first entry, from the head, not earlier than the new one.
          pos = 0;
          while (pos < sched_count && r.due_at > sched_due[pos]) pos++;
          for (int j = sched_count; j > pos; j--) begin
            sched_due[j]  = sched_due[j-1];
            sched_type[j] = sched_type[j-1];
          end
          sched_due[pos]  = r.due_at;
          sched_type[pos] = r.event_type;
          sched_count++;
          if (r.due_at < sched_head) sched_head = r.due_at;
          owe_result(teq_pkg::KIND_ACK, teq_pkg::STATUS_OK, teq_pkg::TYPE_NULL,
                     '0, 1'b1);
        end
      end
      teq_pkg::CMD_RUN: begin
        // Pop while the head is due; null entries leave silently.
        while (sched_count > 0 && sched_head <= r.now) begin
          popped_time = sched_due[0];
          popped_type = sched_type[0];
          sched_count--;
          for (int j = 0; j < sched_count; j++) begin
            sched_due[j]  = sched_due[j+1];
            sched_type[j] = sched_type[j+1];
          end
          sched_head = (sched_count != 0) ? sched_due[0] : teq_pkg::NO_EVENTS;
          if (popped_type != teq_pkg::TYPE_NULL)
            owe_result(teq_pkg::KIND_FIRED, teq_pkg::STATUS_OK, popped_type,
                       popped_time, 1'b0);
        end
        owe_result(teq_pkg::KIND_ACK, teq_pkg::STATUS_OK, teq_pkg::TYPE_NULL, '0, 1'b1);
      end
      teq_pkg::CMD_REBASE: begin
        // Order stays as is even when the subtraction wraps.
        for (int j = 0; j < sched_count; j++) sched_due[j] = sched_due[j] - frame_len;
        sched_head = (sched_count != 0) ? sched_due[0] : teq_pkg::NO_EVENTS;
        n_rebases++;
        owe_result(teq_pkg::KIND_ACK, teq_pkg::STATUS_OK, teq_pkg::TYPE_NULL, '0, 1'b1);
      end
      default: begin
        for (int j = 0; j < sched_count; j++)
          if (sched_type[j] == r.event_type) sched_type[j] = teq_pkg::TYPE_NULL;
        owe_result(teq_pkg::KIND_ACK, teq_pkg::STATUS_OK, teq_pkg::TYPE_NULL, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic teq_pkg::req_t make_req(teq_pkg::cmd_t c, logic [31:0] t,
                                             logic [teq_pkg::TYPE_BITS-1:0] ty,
                                             logic [31:0] at);
    teq_pkg::req_t r;
    r.cmd        = c;
    r.due_at     = t;
    r.event_type = ty;
    r.now        = at;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Drop start for a random gap: mostly none, sometimes short, now and then long.
  task automatic idle_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (quiet_mode || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Present one item from a falling edge and hold it until a rising edge takes it.
  task automatic send_item(input teq_pkg::req_t r);
    start   = 1'b1;
    request = r;
    do @(posedge clk); while (busy);
    queue_apply(r);
    n_items++;
    @(negedge clk);
    idle_gap();
  endtask

  // Hold off until every owed result has shown and the block is free.
  task automatic wait_idle();
    start = 1'b0;
    while (awaited_results.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic read_check_frame();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = FRAME_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== frame_len) begin
      err_count++;
      $display("%0t: frame_length readback, expected %h, got %h", $time, frame_len, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_frame(input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = FRAME_ADDR;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    frame_len = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_check_frame();
  endtask

  task automatic add_event(input logic [31:0] t, input logic [teq_pkg::TYPE_BITS-1:0] ty);
    send_item(make_req(teq_pkg::CMD_ADD, t, ty, $urandom));
  endtask

  // Reset value of the register, and run on an empty queue even with the latest time.
  task automatic test_empty_run();
    read_check_frame();
    send_item(make_req(teq_pkg::CMD_RUN, $urandom, rand_type(), teq_pkg::NO_EVENTS));
    send_item(make_req(teq_pkg::CMD_RUN, $urandom, rand_type(), '0));
    wait_idle();
  endtask

  // Fill with extremes, ties and a null event, then push one more that must be dropped.
  task automatic test_fill_and_overflow();
    add_event(32'd500, 3'd1);
    add_event(32'd0, 3'd7);
    add_event(teq_pkg::NO_EVENTS, 3'd4);
    add_event(32'd500, 3'd2);
    add_event(32'd500, 3'd3);
    add_event(32'd499, teq_pkg::TYPE_NULL);
    add_event(32'd501, 3'd5);
    add_event(32'd1, 3'd6);
    repeat (8) add_event($urandom_range(0, 1000), rand_type());
    add_event(32'd0, 3'd7);
    wait_idle();
  endtask

  // Cancel of the null type changes nothing; a real type turns its entries null.
  task automatic test_cancel();
    send_item(make_req(teq_pkg::CMD_CANCEL, $urandom, teq_pkg::TYPE_NULL, $urandom));
    send_item(make_req(teq_pkg::CMD_CANCEL, $urandom, 3'd3, $urandom));
    wait_idle();
  endtask

  // Pop only what is due at the tie time; popped nulls stay silent.
  task automatic test_partial_run();
    send_item(make_req(teq_pkg::CMD_RUN, $urandom, rand_type(), 32'd500));
    wait_idle();
  endtask

  // Rebase so the remaining times wrap out of order, add into the unsorted queue, drain all.
  task automatic test_rebase_wrap();
    send_item(make_req(teq_pkg::CMD_REBASE, $urandom, rand_type(), $urandom));
    add_event(32'd10, 3'd2);
    add_event(32'hfffe_eef4, 3'd6);
    send_item(make_req(teq_pkg::CMD_RUN, $urandom, rand_type(), teq_pkg::NO_EVENTS));
    wait_idle();
  endtask

  // One phase of random traffic under a given frame length.
  task automatic test_random_traffic(input logic [31:0] frame, input int count, input bit quiet);
    logic [31:0]   epoch;
    int            sel;
    int            burst;
    int            sent;
    teq_pkg::req_t r;
    write_frame(frame);
    quiet_mode = quiet;
    epoch = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
    burst = 0;
    sent  = 0;
    while (sent < count) begin
      sel = $urandom_range(0, 99);
      if (burst > 0) begin
        // Well-formed run of adds to push the queue to full.
        burst--;
        r = make_req(teq_pkg::CMD_ADD, epoch + $urandom_range(0, 3000), rand_type(),
                     $urandom);
      end else if (sel < 8) begin
        r = make_req(rand_cmd(), $urandom, rand_type(), $urandom);
      end else if (sel < 55) begin
        if ($urandom_range(0, 24) == 0) burst = $urandom_range(10, 18);
        r = make_req(teq_pkg::CMD_ADD,
                     ($urandom_range(0, 9) == 0) ? $urandom : epoch + $urandom_range(0, 3000),
                     rand_type(), $urandom);
      end else if (sel < 80) begin
        r = make_req(teq_pkg::CMD_RUN, $urandom, rand_type(),
                     ($urandom_range(0, 14) == 0) ? teq_pkg::NO_EVENTS
                                                  : epoch + $urandom_range(0, 1500));
        epoch = epoch + $urandom_range(0, 400);
      end else if (sel < 90) begin
        r = make_req(teq_pkg::CMD_REBASE, $urandom, rand_type(), $urandom);
        epoch = epoch - frame_len;
      end else begin
        r = make_req(teq_pkg::CMD_CANCEL, $urandom, rand_type(), $urandom);
      end
      send_item(r);
      sent++;
    end
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  // Compare each strobed result with the oldest owed one.
  always @(posedge clk) begin
    teq_pkg::res_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, got %h", $time, result);
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(result.kind));
        check_field("status", 32'(want.status), 32'(result.status));
        check_field("fired_type", 32'(want.fired_type), 32'(result.fired_type));
        check_field("fired_time", want.fired_time, result.fired_time);
        check_field("next_due", want.next_due, result.next_due);
        check_field("last", 32'(want.last), 32'(result.last));
        if (result.kind === teq_pkg::KIND_FIRED) n_fired++;
      end
    end
  end

  // End the run when neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results owed", $time, awaited_results.size());
        $display("timed_event_queue_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_count    = 0;
    n_items      = 0;
    n_fired      = 0;
    n_dropped    = 0;
    n_rebases    = 0;
    quiet_mode   = 1'b0;
    sched_count  = 0;
    sched_head   = teq_pkg::NO_EVENTS;
    frame_len    = teq_pkg::FRAME_RESET;
    for (int j = 0; j < DEPTH; j++) begin
      sched_due[j]  = '0;
      sched_type[j] = teq_pkg::TYPE_NULL;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_run();
    test_fill_and_overflow();
    test_cancel();
    test_partial_run();
    test_rebase_wrap();
    test_random_traffic('0, 90, 1'b0);
    test_random_traffic(teq_pkg::NO_EVENTS, 90, 1'b1);
    test_random_traffic(teq_pkg::FRAME_RESET, 90, 1'b0);
    test_random_traffic($urandom, 90, 1'b0);
    test_random_traffic($urandom_range(1, 64), 90, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    $display("covered %0d commands: %0d events fired, %0d adds dropped on a full queue",
             n_items, n_fired, n_dropped);
    $display("%0d rebases across frame lengths of zero, all ones, reset, random and small",
             n_rebases);
    if (err_count == 0) begin
      $display("timed_event_queue_tb: clean");
    end else begin
      $display("timed_event_queue_tb: errors");
    end
    $finish;
  end

endmodule

// ===== timed_event_queue.f =====
+incdir+rtl/core
rtl/core/teq_pkg.sv
rtl/core/teq_cell.sv
rtl/core/timed_event_queue.sv
bench/timed_event_queue_tb.sv
